>>> hdl/hrlc_pkg.sv
`default_nettype none

package hrlc_pkg;

    localparam int PATH_LIMIT_DEFAULT = 64;
    localparam int METHOD_COUNT = 5;
    localparam int VERSION_COUNT = 3;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [6:0] TOKEN_POS_MAX = 7'd127;

    localparam logic [1:0] VERDICT_OK = 2'd0;
    localparam logic [1:0] VERDICT_BAD_REQUEST = 2'd1;
    localparam logic [1:0] VERDICT_PATH_TOO_LONG = 2'd2;
    localparam logic [1:0] VERDICT_BAD_VERSION = 2'd3;

    localparam logic [2:0] METHOD_GET = 3'd0;
    localparam logic [2:0] METHOD_POST = 3'd1;
    localparam logic [2:0] METHOD_PUT = 3'd2;
    localparam logic [2:0] METHOD_PATCH = 3'd3;
    localparam logic [2:0] METHOD_DELETE = 3'd4;
    localparam logic [2:0] METHOD_NONE = 3'd5;

    localparam logic [1:0] VERSION_1_0 = 2'd0;
    localparam logic [1:0] VERSION_1_1 = 2'd1;
    localparam logic [1:0] VERSION_2 = 2'd2;
    localparam logic [1:0] VERSION_NONE = 2'd3;

    // Token texts are right-justified: the last character sits in bits [7:0].
    localparam logic [47:0] METHOD_TEXT [METHOD_COUNT] = '{
        48'("GET"), 48'("POST"), 48'("PUT"), 48'("PATCH"), 48'("DELETE")
    };
    localparam logic [2:0] METHOD_LEN [METHOD_COUNT] = '{3'd3, 3'd4, 3'd3, 3'd5, 3'd6};

    localparam logic [63:0] VERSION_TEXT [VERSION_COUNT] = '{
        64'("HTTP/1.0"), 64'("HTTP/1.1"), 64'("HTTP/2")
    };
    localparam logic [3:0] VERSION_LEN [VERSION_COUNT] = '{4'd8, 4'd8, 4'd6};

    typedef struct packed {
        logic       valid;
        logic       eol;
        logic [7:0] line_byte;
    } t_step;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] method_code;
        logic [1:0] version_code;
        logic [6:0] path_length;
    } t_result;

    function automatic logic [METHOD_COUNT-1:0] method_byte_mask(
        input logic [6:0] pos,
        input logic [7:0] c
    );
        logic [METHOD_COUNT-1:0] m;
        logic [2:0]              sh;
        logic [47:0]             t;
        m = '0;
        for (int i = 0; i < METHOD_COUNT; i++) begin
            sh = METHOD_LEN[i] - 3'd1 - pos[2:0];
            t  = METHOD_TEXT[i] >> {sh, 3'b000};
            m[i] = (pos < {4'd0, METHOD_LEN[i]}) && (t[7:0] == c);
        end
        return m;
    endfunction

    function automatic logic [VERSION_COUNT-1:0] version_byte_mask(
        input logic [6:0] pos,
        input logic [7:0] c
    );
        logic [VERSION_COUNT-1:0] m;
        logic [3:0]               sh;
        logic [63:0]              t;
        m = '0;
        for (int i = 0; i < VERSION_COUNT; i++) begin
            sh = VERSION_LEN[i] - 4'd1 - {1'b0, pos[2:0]};
            t  = VERSION_TEXT[i] >> {sh[2:0], 3'b000};
            m[i] = (pos < {3'd0, VERSION_LEN[i]}) && (t[7:0] == c);
        end
        return m;
    endfunction

    function automatic logic [METHOD_COUNT-1:0] method_len_mask(input logic [6:0] pos);
        logic [METHOD_COUNT-1:0] m;
        for (int i = 0; i < METHOD_COUNT; i++) begin
            m[i] = (pos == {4'd0, METHOD_LEN[i]});
        end
        return m;
    endfunction

    function automatic logic [VERSION_COUNT-1:0] version_len_mask(input logic [6:0] pos);
        logic [VERSION_COUNT-1:0] m;
        for (int i = 0; i < VERSION_COUNT; i++) begin
            m[i] = (pos == {3'd0, VERSION_LEN[i]});
        end
        return m;
    endfunction

    function automatic logic [2:0] method_first(input logic [METHOD_COUNT-1:0] m);
        logic [2:0] code;
        if (m[0]) begin
            code = METHOD_GET;
        end else if (m[1]) begin
            code = METHOD_POST;
        end else if (m[2]) begin
            code = METHOD_PUT;
        end else if (m[3]) begin
            code = METHOD_PATCH;
        end else if (m[4]) begin
            code = METHOD_DELETE;
        end else begin
            code = METHOD_NONE;
        end
        return code;
    endfunction

    function automatic logic [1:0] version_first(input logic [VERSION_COUNT-1:0] m);
        logic [1:0] code;
        if (m[0]) begin
            code = VERSION_1_0;
        end else if (m[1]) begin
            code = VERSION_1_1;
        end else if (m[2]) begin
            code = VERSION_2;
        end else begin
            code = VERSION_NONE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> hdl/http_request_line_checker.sv
// A terminator is taken into the input register, and its verdict is then registered in the
// output register, which it enters once the previous result is gone or is being taken.
// Throughput: one byte per cycle, set by the parse step; a terminator whose
// previous result is still stalled waits in the input register and holds the input.
// Reset: i_rst_n is synchronous and active low; it empties both registers and returns
// the parser to the start of a line.
`default_nettype none

module http_request_line_checker import hrlc_pkg::*; #(
    parameter int PATH_LIMIT = PATH_LIMIT_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] line_byte
    input  wire logic        i_s_tlast,   // end_of_line
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [1:0] verdict, [4:2] method_code,
                                          // [6:5] version_code, [13:7] path_length
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eol;
    logic       r_out_valid;
    t_result    r_out;

    logic    out_free;
    logic    proc;
    t_step   step;
    t_result result;

    assign out_free   = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && (!r_in_eol || out_free);
    assign o_s_tready = !r_in_valid || proc;

    assign step.valid     = proc;
    assign step.eol       = r_in_eol;
    assign step.line_byte = r_in_byte;

    hrlc_parse #(
        .PATH_LIMIT(PATH_LIMIT)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_eol  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_eol) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_eol) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.path_length, r_out.version_code,
                         r_out.method_code, r_out.verdict};

endmodule

`default_nettype wire

>>> hdl/hrlc_parse.sv
`default_nettype none

module hrlc_parse import hrlc_pkg::*; #(
    parameter int PATH_LIMIT = PATH_LIMIT_DEFAULT
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_step   i_step,
    output t_result      o_result
);

    localparam int PATH_W = $clog2(PATH_LIMIT + 2);
    localparam logic [PATH_W-1:0] PATH_SAT = PATH_W'(PATH_LIMIT + 1);
    localparam logic [PATH_W-1:0] PATH_MAX = PATH_W'(PATH_LIMIT);
    localparam logic [PATH_W-1:0] PATH_ONE = PATH_W'(1);

    logic [1:0]               r_token_number, n_token_number;
    logic [6:0]               r_token_pos, n_token_pos;
    logic [METHOD_COUNT-1:0]  r_method_cand, n_method_cand;
    logic [VERSION_COUNT-1:0] r_version_cand, n_version_cand;
    logic [PATH_W-1:0]        r_path_count, n_path_count;
    logic                     r_path_slash, n_path_slash;
    logic                     r_between, n_between;
    logic                     r_extra, n_extra;

    logic [METHOD_COUNT-1:0]  close_method;
    logic [VERSION_COUNT-1:0] close_version;
    logic [2:0]               method_code;
    logic [1:0]               version_code;
    logic [PATH_W+6:0]        path_ext;
    logic [1:0]               tn_open;
    logic                     extra_open;
    logic [6:0]               byte_pos;

    // Position of the current byte inside its token.
    assign byte_pos = r_between ? 7'd0 : r_token_pos;

    // The candidate sets as they stand once the current token is closed.
    always_comb begin
        close_method  = r_method_cand;
        close_version = r_version_cand;
        if (!r_between && !r_extra) begin
            if (r_token_number == 2'd1) begin
                close_method = r_method_cand & method_len_mask(r_token_pos);
            end
            if (r_token_number == 2'd3) begin
                close_version = r_version_cand & version_len_mask(r_token_pos);
            end
        end
    end

    always_comb begin
        method_code  = (r_token_number >= 2'd1) ? method_first(close_method) : METHOD_NONE;
        version_code = (r_token_number >= 2'd3) ? version_first(close_version) : VERSION_NONE;
        path_ext     = {7'd0, r_path_count};
        o_result.method_code  = method_code;
        o_result.version_code = version_code;
        o_result.path_length  = path_ext[6:0];
        if (method_code == METHOD_NONE || r_token_number != 2'd3 || r_extra) begin
            o_result.verdict = VERDICT_BAD_REQUEST;
        end else if (version_code == VERSION_NONE) begin
            o_result.verdict = VERDICT_BAD_VERSION;
        end else if (r_path_count == PATH_ONE && !r_path_slash) begin
            o_result.verdict = VERDICT_BAD_REQUEST;
        end else if (r_path_count > PATH_MAX) begin
            o_result.verdict = VERDICT_PATH_TOO_LONG;
        end else begin
            o_result.verdict = VERDICT_OK;
        end
    end

    always_comb begin
        n_token_number = r_token_number;
        n_token_pos    = r_token_pos;
        n_method_cand  = r_method_cand;
        n_version_cand = r_version_cand;
        n_path_count   = r_path_count;
        n_path_slash   = r_path_slash;
        n_between      = r_between;
        n_extra        = r_extra;
        tn_open        = r_token_number;
        extra_open     = r_extra;
        if (i_step.valid) begin
            if (i_step.eol) begin
                n_token_number = 2'd0;
                n_token_pos    = 7'd0;
                n_method_cand  = '1;
                n_version_cand = '1;
                n_path_count   = '0;
                n_path_slash   = 1'b0;
                n_between      = 1'b1;
                n_extra        = 1'b0;
            end else if (i_step.line_byte == SPACE_CHAR) begin
                n_method_cand  = close_method;
                n_version_cand = close_version;
                n_between      = 1'b1;
            end else begin
                if (r_between) begin
                    if (r_token_number == 2'd3) begin
                        extra_open = 1'b1;
                    end else begin
                        tn_open = r_token_number + 2'd1;
                    end
                    n_token_number = tn_open;
                    n_extra        = extra_open;
                    n_between      = 1'b0;
                end
                if (!extra_open) begin
                    if (tn_open == 2'd1) begin
                        n_method_cand = r_method_cand
                                      & method_byte_mask(byte_pos, i_step.line_byte);
                    end else if (tn_open == 2'd2) begin
                        if (r_between) begin
                            n_path_count = PATH_ONE;
                            n_path_slash = (i_step.line_byte == SLASH_CHAR);
                        end else if (r_path_count < PATH_SAT) begin
                            n_path_count = r_path_count + PATH_ONE;
                        end
                    end else if (tn_open == 2'd3) begin
                        n_version_cand = r_version_cand
                                       & version_byte_mask(byte_pos, i_step.line_byte);
                    end
                end
                if (r_between) begin
                    n_token_pos = 7'd1;
                end else if (r_token_pos < TOKEN_POS_MAX) begin
                    n_token_pos = r_token_pos + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_number <= 2'd0;
            r_token_pos    <= 7'd0;
            r_method_cand  <= '1;
            r_version_cand <= '1;
            r_path_count   <= '0;
            r_path_slash   <= 1'b0;
            r_between      <= 1'b1;
            r_extra        <= 1'b0;
        end else begin
            r_token_number <= n_token_number;
            r_token_pos    <= n_token_pos;
            r_method_cand  <= n_method_cand;
            r_version_cand <= n_version_cand;
            r_path_count   <= n_path_count;
            r_path_slash   <= n_path_slash;
            r_between      <= n_between;
            r_extra        <= n_extra;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hrlc_checker.sv
`default_nettype none

module hrlc_checker import hrlc_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tlast,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata
);

    // A result under backpressure keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // An accepted verdict implies a known method and version.
    a_ok_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == VERDICT_OK |->
            o_m_tdata[4:2] != METHOD_NONE && o_m_tdata[6:5] != VERSION_NONE)
        else $error("ok verdict with unknown method or version");

    // Version rejection only follows a valid method and an unknown version.
    a_version_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == VERDICT_BAD_VERSION |->
            o_m_tdata[4:2] != METHOD_NONE && o_m_tdata[6:5] == VERSION_NONE)
        else $error("version verdict inconsistent with codes");

    // No result can follow a reset directly.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result present after reset");

    // A result cannot rise without an earlier terminator transaction in the input register.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && !(i_s_tvalid && o_s_tready && i_s_tlast) ##1 !o_m_tvalid
            |=> !o_m_tvalid)
        else $error("result appeared without a terminator");

endmodule

bind http_request_line_checker hrlc_checker u_hrlc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tlast (i_s_tlast),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

`default_nettype wire

>>> tb/tb_http_request_line_checker.sv
`default_nettype none

module tb_http_request_line_checker;
    import hrlc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_BEATS = 1350;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } t_line_beat;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_data;

    t_line_beat beat_q[$];
    t_result    verdict_q[$];
    bit         hold_next = 1'b0;
    int         beats_total = 0;
    int         beats_taken = 0;
    int         fault_cnt = 0;
    int         cycle_cnt = 0;
    int         send_wait = 0;
    int         recv_wait = 0;
    int         calm_left[2] = '{0, 0};

    // Parser state of the expected behavior.
    int unsigned tok_cnt;
    int unsigned tok_pos;
    int unsigned path_cnt;
    logic [4:0]  meth_live;
    logic [2:0]  ver_live;
    bit          path_slash;
    bit          in_gap;
    bit          extra_tok;

    always #5 clk = ~clk;

    http_request_line_checker u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    function automatic logic [2:0] method_info(input int idx, output string w);
        case (idx)
            0: begin w = "GET"; return METHOD_GET; end
            1: begin w = "POST"; return METHOD_POST; end
            2: begin w = "PUT"; return METHOD_PUT; end
            3: begin w = "PATCH"; return METHOD_PATCH; end
            default: begin w = "DELETE"; return METHOD_DELETE; end
        endcase
    endfunction

    function automatic logic [1:0] version_info(input int idx, output string w);
        case (idx)
            0: begin w = "HTTP/1.0"; return VERSION_1_0; end
            1: begin w = "HTTP/1.1"; return VERSION_1_1; end
            default: begin w = "HTTP/2"; return VERSION_2; end
        endcase
    endfunction

    task automatic clear_line();
        tok_cnt = 0;
        tok_pos = 0;
        path_cnt = 0;
        meth_live = '1;
        ver_live = '1;
        path_slash = 1'b0;
        in_gap = 1'b1;
        extra_tok = 1'b0;
    endtask

    task automatic close_token();
        string w;
        logic [2:0] mc;
        logic [1:0] vc;
        if (!extra_tok) begin
            if (tok_cnt == 1) begin
                for (int i = 0; i < METHOD_COUNT; i++) begin
                    mc = method_info(i, w);
                    if (w.len() != tok_pos) meth_live[i] = 1'b0;
                end
            end else if (tok_cnt == 3) begin
                for (int i = 0; i < VERSION_COUNT; i++) begin
                    vc = version_info(i, w);
                    if (w.len() != tok_pos) ver_live[i] = 1'b0;
                end
            end
        end
        in_gap = 1'b1;
    endtask

    task automatic parse_line_byte(input logic [7:0] c, input logic eol);
        string      w;
        logic [2:0] mc;
        logic [1:0] vc;
        logic [2:0] mcode;
        logic [1:0] vcode;
        t_result    r;
        if (eol) begin
            if (!in_gap) close_token();
            mcode = METHOD_NONE;
            vcode = VERSION_NONE;
            if (tok_cnt >= 1) begin
                for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
                    mc = method_info(i, w);
                    if (meth_live[i]) mcode = mc;
                end
            end
            if (tok_cnt >= 3) begin
                for (int i = VERSION_COUNT - 1; i >= 0; i--) begin
                    vc = version_info(i, w);
                    if (ver_live[i]) vcode = vc;
                end
            end
            if (mcode == METHOD_NONE || tok_cnt != 3 || extra_tok) begin
                r.verdict = VERDICT_BAD_REQUEST;
            end else if (vcode == VERSION_NONE) begin
                r.verdict = VERDICT_BAD_VERSION;
            end else if (path_cnt == 1 && !path_slash) begin
                r.verdict = VERDICT_BAD_REQUEST;
            end else if (path_cnt > PATH_LIMIT_DEFAULT) begin
                r.verdict = VERDICT_PATH_TOO_LONG;
            end else begin
                r.verdict = VERDICT_OK;
            end
            r.method_code = mcode;
            r.version_code = vcode;
            r.path_length = 7'(path_cnt);
            verdict_q.push_back(r);
            clear_line();
        end else if (c == SPACE_CHAR) begin
            if (!in_gap) close_token();
        end else begin
            if (in_gap) begin
                if (tok_cnt == 3) extra_tok = 1'b1;
                else tok_cnt++;
                tok_pos = 0;
                if (!extra_tok && tok_cnt == 2) begin
                    path_cnt = 0;
                    path_slash = (c == SLASH_CHAR);
                end
                in_gap = 1'b0;
            end
            if (!extra_tok) begin
                if (tok_cnt == 1) begin
                    for (int i = 0; i < METHOD_COUNT; i++) begin
                        mc = method_info(i, w);
                        if (tok_pos >= w.len() || w[tok_pos] != c) meth_live[i] = 1'b0;
                    end
                end else if (tok_cnt == 2) begin
                    if (path_cnt < PATH_LIMIT_DEFAULT + 1) path_cnt++;
                end else if (tok_cnt == 3) begin
                    for (int i = 0; i < VERSION_COUNT; i++) begin
                        vc = version_info(i, w);
                        if (tok_pos >= w.len() || w[tok_pos] != c) ver_live[i] = 1'b0;
                    end
                end
            end
            if (tok_pos < TOKEN_POS_MAX) tok_pos++;
        end
    endtask

    task automatic push_beat(input logic [7:0] b, input logic last);
        t_line_beat nb;
        nb.data = b;
        nb.last = last;
        nb.hold = hold_next;
        hold_next = 1'b0;
        beat_q.push_back(nb);
    endtask

    task automatic push_word(input string s);
        for (int k = 0; k < s.len(); k++) push_beat(s[k], 1'b0);
    endtask

    task automatic end_line();
        push_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == SPACE_CHAR) b = SLASH_CHAR;
        return b;
    endfunction

    task automatic put_junk(input int n);
        repeat (n) push_beat(text_byte(), 1'b0);
    endtask

    task automatic put_spaces();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(2, 4)) push_beat(SPACE_CHAR, 1'b0);
        else push_beat(SPACE_CHAR, 1'b0);
    endtask

    task automatic put_known(input string w);
        int mode;
        int pos;
        mode = $urandom_range(0, 9);
        pos = $urandom_range(0, w.len() - 1);
        case (mode)
            6: for (int k = 0; k < w.len() - 1; k++) push_beat(w[k], 1'b0);
            7: begin
                push_word(w);
                put_junk(1);
            end
            8: for (int k = 0; k < w.len(); k++) push_beat((k == pos) ? text_byte() : w[k], 1'b0);
            9: begin
                push_word(w);
                if ($urandom_range(0, 7) == 0) put_junk($urandom_range(120, 135));
                else put_junk($urandom_range(1, 3));
            end
            default: push_word(w);
        endcase
    endtask

    task automatic put_path();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            push_beat(SLASH_CHAR, 1'b0);
            put_junk($urandom_range(0, 12));
        end else if (r < 70) begin
            push_beat(SLASH_CHAR, 1'b0);
            put_junk($urandom_range(58, 70));
        end else if (r < 80) begin
            put_junk(1);
        end else if (r < 88) begin
            push_beat(SLASH_CHAR, 1'b0);
        end else if (r < 96) begin
            put_junk($urandom_range(1, 10));
        end else begin
            put_junk($urandom_range(100, 130));
        end
    endtask

    task automatic random_line();
        string      w;
        logic [2:0] mc;
        logic [1:0] vc;
        int         r;
        int         ntok;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            repeat ($urandom_range(0, 24)) begin
                if ($urandom_range(0, 3) == 0) push_beat(SPACE_CHAR, 1'b0);
                else push_beat(8'($urandom_range(0, 255)), 1'b0);
            end
        end else begin
            ntok = (r < 25) ? $urandom_range(0, 5) : 3;
            if ($urandom_range(0, 4) == 0) put_spaces();
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) put_spaces();
                case (t)
                    0: begin
                        mc = method_info($urandom_range(0, METHOD_COUNT - 1), w);
                        if ($urandom_range(0, 9) == 0) put_junk($urandom_range(1, 6));
                        else put_known(w);
                    end
                    1: put_path();
                    2: begin
                        vc = version_info($urandom_range(0, VERSION_COUNT - 1), w);
                        put_known(w);
                    end
                    default: put_junk($urandom_range(1, 8));
                endcase
            end
            if ($urandom_range(0, 4) == 0) put_spaces();
        end
        end_line();
    endtask

    function automatic int next_gap(input int side);
        int r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin
        t_line_beat nb;
        if (!rst_n) begin
            s_valid <= 1'b0;
            s_data <= '0;
            s_last <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_line_byte(s_data, s_last);
                beats_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (beat_q.size() > 0 && !(beat_q[0].hold && verdict_q.size() > 0)) begin
                    nb = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_data <= nb.data;
                    s_last <= nb.last;
                    send_wait = next_gap(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.verdict = m_data[1:0];
                got.method_code = m_data[4:2];
                got.version_code = m_data[6:5];
                got.path_length = m_data[13:7];
                if (verdict_q.size() == 0) begin
                    if (fault_cnt < 10) begin
                        $display("unexpected result: verdict %0d method %0d version %0d path %0d",
                                 got.verdict, got.method_code, got.version_code,
                                 got.path_length);
                    end
                    fault_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.verdict !== want.verdict || got.method_code !== want.method_code ||
                        got.version_code !== want.version_code ||
                        got.path_length !== want.path_length) begin
                        if (fault_cnt < 10) begin
                            $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                     want.verdict, want.method_code, want.version_code,
                                     want.path_length, got.verdict, got.method_code,
                                     got.version_code, got.path_length);
                        end
                        fault_cnt++;
                    end
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_wait = next_gap(1);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("http_request_line_checker test failed");
            $finish;
        end
    end

    initial begin
        int lines;
        clear_line();

        end_line();
        push_word("GET / HTTP/1.1");
        end_line();
        push_word("POST /a HTTP/1.0");
        end_line();
        push_word("PUT /x/y HTTP/2");
        end_line();
        push_word("PATCH /p HTTP/1.1");
        end_line();
        push_word("DELETE /d HTTP/1.0");
        end_line();
        push_word("  GET   /   HTTP/2   ");
        end_line();
        push_word("GET x HTTP/1.1");
        end_line();
        push_word("GETS / HTTP/1.1");
        end_line();
        push_word("GET / HTTP/3");
        end_line();
        push_word("GET x HTTP/3");
        end_line();
        push_word("GET /");
        end_line();
        push_word("GET / HTTP/1.1 a b");
        end_line();
        push_word("BAD x HTTP/9");
        end_line();
        push_word("GET\t/ HTTP/1.1\r");
        end_line();
        push_word("GET /");
        push_beat(8'h00, 1'b0);
        push_word(" HTTP/1.1");
        end_line();
        push_word("GET /");
        put_junk(PATH_LIMIT_DEFAULT - 1);
        push_word(" HTTP/1.1");
        end_line();
        push_word("PUT /");
        put_junk(PATH_LIMIT_DEFAULT);
        push_word(" HTTP/2");
        end_line();
        push_word("GET");
        put_junk(130);
        push_word(" / HTTP/1.1");
        end_line();

        lines = 0;
        while (beat_q.size() < TOTAL_BEATS) begin
            if (lines % 20 == 0) hold_next = 1'b1;
            random_line();
            lines++;
        end
        beats_total = beat_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (beats_taken < beats_total || verdict_q.size() != 0);
        repeat (8) @(negedge clk);
        if (verdict_q.size() != 0) begin
            $display("%0d expected results never arrived", verdict_q.size());
            fault_cnt++;
        end
        if (fault_cnt == 0) begin
            $display("http_request_line_checker test passed");
        end else begin
            $display("http_request_line_checker test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/hrlc_pkg.sv
hdl/hrlc_parse.sv
hdl/http_request_line_checker.sv
hdl/hrlc_checker.sv
tb/tb_http_request_line_checker.sv
